@@ rtl/wwet_pkg.sv @@
// ----------------------------------------------------------------------------
// wwet_pkg
// Shared constants and types for the windowed waste EMA tuner.
// ----------------------------------------------------------------------------
package wwet_pkg;

  localparam int W_BITS = 19;
  localparam int Q16_BITS = 18;   // signal range 0..131072

  localparam logic [W_BITS-1:0] ONE_Q16     = 19'd65536;
  localparam logic [W_BITS-1:0] TWO_Q16     = 19'd131072;
  localparam logic [W_BITS-1:0] FOUR_Q16    = 19'd262144;
  localparam logic [W_BITS-1:0] QUARTER_Q16 = 19'd16384;

  localparam logic [0:0] CFG_GAIN = 1'b0;
  localparam logic [0:0] CFG_MINS = 1'b1;

  typedef logic [W_BITS-1:0] weight_t;

  // start/done handshake between the top level and the serial divider or EMA unit
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

@@ rtl/wwet_div.sv @@
// ----------------------------------------------------------------------------
// wwet_div
// Restoring bit-serial divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wwet_div #(
  parameter int NUM_BITS = 70,
  parameter int DEN_BITS = 64,
  parameter int Q_BITS   = 70
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wwet_pkg::div_ctl_t   ctl,
  input  logic [NUM_BITS-1:0]  num,
  input  logic [DEN_BITS-1:0]  den,
  output wwet_pkg::div_sts_t   sts,
  output logic [Q_BITS-1:0]    quo
);
  import wwet_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] sh_r, sh_nxt;
  logic [DEN_BITS:0]   rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [DEN_BITS:0]   trial;

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_BITS-1:0], sh_r[NUM_BITS-1]};
    if (ctl.start) begin
      sh_nxt   = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_BITS'(NUM_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract when it fits; quotient fills sh
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        sh_nxt  = {sh_r[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        sh_nxt  = {sh_r[NUM_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    if (ctl.start) den_r <= den;
  end

  assign sts.done = done_r;
  assign quo      = Q_BITS'(sh_r);

endmodule

@@ rtl/wwet_ema.sv @@
// ----------------------------------------------------------------------------
// wwet_ema
// EMA step of one weight toward a target: MSB-first shift-add product of the difference and the gain.
// ----------------------------------------------------------------------------
module wwet_ema (
  input  logic               clk,
  input  logic               rst_n,
  input  wwet_pkg::div_ctl_t ctl,
  input  logic [5:0]         gain,
  input  wwet_pkg::weight_t  old_w,
  input  wwet_pkg::weight_t  target,
  output wwet_pkg::div_sts_t sts,
  output wwet_pkg::weight_t  new_w
);
  import wwet_pkg::*;

  logic [W_BITS+5:0] acc_r;
  logic [W_BITS-1:0] diff_r, old_r;
  logic [5:0]        g_r;
  logic              up_r;
  logic [2:0]        cnt_r;
  logic              busy_r, done_r;
  logic [W_BITS:0]   delta, w;

  always_comb begin
    delta = (W_BITS+1)'(acc_r >> 6);
    if (up_r) w = {1'b0, old_r} + delta;
    else if ({1'b0, old_r} > delta) w = {1'b0, old_r} - delta;
    else w = (W_BITS+1)'(1);
    if (w > {1'b0, FOUR_Q16}) w = {1'b0, FOUR_Q16};
    if (w < {1'b0, QUARTER_Q16}) w = {1'b0, QUARTER_Q16};
    new_w = W_BITS'(w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd6;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 3'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (ctl.start) begin
      up_r   <= target > old_w;
      diff_r <= (target > old_w) ? target - old_w : old_w - target;
      old_r  <= old_w;
      g_r    <= gain;
      acc_r  <= '0;
    end else if (busy_r) begin
      // MSB-first shift-add of diff by the gain
      acc_r <= (acc_r << 1) + (g_r[5] ? (W_BITS+6)'(diff_r) : '0);
      g_r   <= {g_r[4:0], 1'b0};
    end
  end

  assign sts.done = done_r;

endmodule

@@ rtl/windowed_waste_ema_tuner.sv @@
// ----------------------------------------------------------------------------
// windowed_waste_ema_tuner
// Windowed demand/shortfall tracker with EMA-tuned cost weights.
// ----------------------------------------------------------------------------
// One transfer in at a time. The sample is stored in a WINDOW_DEPTH ring
// (one memory port, read then written), and the window sums are updated.
// Then one bit-serial divider works through the three waste signals and the
// gpu demand average, one after the other. The divide-by-64 of the demand sum
// is a shift. A shift-add unit then moves each weight, one after the other.
// An item that produces a result holds the block from its accepting edge
// until it returns to idle, so the next input waits; the four serial
// divides set most of that time. An item below min_samples returns to idle
// right after the window update. After reset the ring is cleared entry by
// entry in one pass, and no input is taken during the pass. Results wait
// in an output register. The next input is accepted while a result waits.
// A new result stalls until the waiting one has been taken.
// ----------------------------------------------------------------------------
module windowed_waste_ema_tuner #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_cpu_demand,
  input  logic [31:0] in_cpu_granted,
  input  logic [31:0] in_ram_demand,
  input  logic [31:0] in_ram_granted,
  input  logic [31:0] in_gpu_demand,
  input  logic [31:0] in_gpu_granted,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [18:0] out_weight_cpu,
  output logic [18:0] out_weight_ram,
  output logic [18:0] out_weight_gpu,
  output logic [6:0]  out_cpu_bias,
  output logic [31:0] out_gpu_demand_avg,
  output logic [3:0]  out_ram_readahead,
  output logic [7:0]  out_reclaim_level
);
  import wwet_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = SAMPLE_BITS + CW;           // window sum width
  localparam int NB = SW + 16;                    // dividend width
  localparam int DB = SW;                          // divisor width

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_DWAIT = 4'd5;
  localparam logic [3:0] S_EMA   = 4'd6;
  localparam logic [3:0] S_EWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_r;
  logic [1:0] res_r;          // resource under work; 3 = gpu average divide
  logic [AW-1:0] widx_r, clr_r;
  logic [CW-1:0] fill_r;
  logic [5:0] gain_r;
  logic [6:0] mins_r;

  logic [6*SAMPLE_BITS-1:0] ring [WINDOW_DEPTH];
  logic [6*SAMPLE_BITS-1:0] old_q_r, new_r;
  logic [SW-1:0] dsum_r [3];
  logic [SW-1:0] ssum_r [3];
  logic [Q16_BITS-1:0] sig_r [3];
  weight_t wt_r [3];
  logic [31:0] burst_r;

  logic out_busy_r;

  // ---- serial divider
  div_ctl_t dctl;
  div_sts_t dsts;
  logic [NB-1:0] dnum;
  logic [DB-1:0] dden;
  logic [NB-1:0] dquo;
  wwet_div #(.NUM_BITS(NB), .DEN_BITS(DB), .Q_BITS(NB)) u_div (
    .clk, .rst_n, .ctl(dctl), .num(dnum), .den(dden), .sts(dsts), .quo(dquo)
  );

  // ---- EMA unit
  div_ctl_t ectl;
  div_sts_t ests;
  weight_t  etarget, enew;
  wwet_ema u_ema (
    .clk, .rst_n, .ctl(ectl), .gain(gain_r), .old_w(wt_r[res_r]),
    .target(etarget), .sts(ests), .new_w(enew)
  );

  function automatic logic [SAMPLE_BITS-1:0] shortfall(
    input logic [SAMPLE_BITS-1:0] d, input logic [SAMPLE_BITS-1:0] g);
    return (d > g) ? d - g : '0;
  endfunction

  // divider operands
  logic [SW-1:0] dsel, ssel, div64;
  always_comb begin
    dsel  = dsum_r[res_r[1:0] == 2'd3 ? 2'd2 : res_r];
    ssel  = ssum_r[res_r[1:0] == 2'd3 ? 2'd2 : res_r];
    div64 = dsel >> 6;
    if (div64 == '0) div64 = SW'(1);
    if (res_r == 2'd3) begin
      dnum = NB'(dsum_r[2]);
      dden = DB'(fill_r);
    end else begin
      dnum = {ssel, 16'd0};
      dden = div64;
    end
  end

  // capped signal from quotient
  logic [Q16_BITS-1:0] sig_val;
  always_comb begin
    if (dsel == '0) sig_val = Q16_BITS'(ONE_Q16);
    else if (dquo >= NB'(TWO_Q16)) sig_val = Q16_BITS'(TWO_Q16);
    else sig_val = Q16_BITS'(dquo);
  end

  always_comb begin
    etarget = W_BITS'(sig_r[res_r]);
    if (res_r == 2'd0)
      etarget = ({1'b0, sig_r[0]} > ONE_Q16) ? TWO_Q16 - {1'b0, sig_r[0]} : ONE_Q16;
  end

  assign in_ready = (state_r == S_IDLE);
  assign dctl.start = (state_r == S_DIV);
  assign ectl.start = (state_r == S_EMA);

  logic [CW-1:0] fill_nxt;
  always_comb begin
    fill_nxt = fill_r;
    if (fill_r != CW'(WINDOW_DEPTH)) fill_nxt = fill_r + 1'b1;
  end

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 6'd3;
      mins_r <= 7'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN: gain_r <= cfg_data[5:0];
        CFG_MINS: mins_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (state_r == S_CLR) ring[clr_r] <= '0;
    else if (state_r == S_UPD) ring[widx_r] <= new_r;
    old_q_r <= ring[widx_r];
  end

  logic [6:0] mins_eff;
  assign mins_eff = (mins_r == 7'd0) ? 7'd1 : mins_r;

  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_busy_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      widx_r     <= '0;
      fill_r     <= '0;
      res_r      <= '0;
      out_busy_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        dsum_r[k] <= '0;
        ssum_r[k] <= '0;
        wt_r[k]   <= ONE_Q16;
      end
    end else begin
      if (out_load) out_busy_r <= 1'b1;
      else if (out_valid && out_ready) out_busy_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(WINDOW_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            new_r <= {SAMPLE_BITS'(in_gpu_granted), SAMPLE_BITS'(in_gpu_demand),
                      SAMPLE_BITS'(in_ram_granted), SAMPLE_BITS'(in_ram_demand),
                      SAMPLE_BITS'(in_cpu_granted), SAMPLE_BITS'(in_cpu_demand)};
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_UPD;
        S_UPD: begin
          for (int k = 0; k < 3; k++) begin
            dsum_r[k] <= dsum_r[k]
              - SW'(old_q_r[2*k*SAMPLE_BITS +: SAMPLE_BITS])
              + SW'(new_r[2*k*SAMPLE_BITS +: SAMPLE_BITS]);
            ssum_r[k] <= ssum_r[k]
              - SW'(shortfall(old_q_r[2*k*SAMPLE_BITS +: SAMPLE_BITS],
                              old_q_r[(2*k+1)*SAMPLE_BITS +: SAMPLE_BITS]))
              + SW'(shortfall(new_r[2*k*SAMPLE_BITS +: SAMPLE_BITS],
                              new_r[(2*k+1)*SAMPLE_BITS +: SAMPLE_BITS]));
          end
          widx_r <= (widx_r == AW'(WINDOW_DEPTH - 1)) ? '0 : widx_r + 1'b1;
          fill_r <= fill_nxt;
          res_r  <= '0;
          if (32'(fill_nxt) < 32'(mins_eff))
            state_r <= S_IDLE;
          else
            state_r <= S_DIV;
        end
        S_DIV: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (dsts.done) begin
            if (res_r == 2'd3) begin
              burst_r <= 32'(dquo);
              res_r   <= '0;
              state_r <= S_EMA;
            end else begin
              sig_r[res_r] <= sig_val;
              res_r   <= res_r + 1'b1;
              state_r <= S_DIV;
            end
          end
        end
        S_EMA: state_r <= S_EWAIT;
        S_EWAIT: begin
          if (ests.done) begin
            wt_r[res_r] <= enew;
            if (res_r == 2'd2) state_r <= S_OUT;
            else begin
              res_r   <= res_r + 1'b1;
              state_r <= S_EMA;
            end
          end
        end
        S_OUT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  logic [2:0] ipc, ipr;
  logic [7:0] bias, recl;
  always_comb begin
    ipc  = wt_r[0][18:16];
    ipr  = wt_r[1][18:16];
    bias = 8'd50 + 8'(ipc) * 8'd10;
    if (bias > 8'd90) bias = 8'd90;
    // at most 64 + 16 * 7, so no saturation is reached
    recl = 8'd64 + 8'(ipr) * 8'd16;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_weight_cpu     <= wt_r[0];
      out_weight_ram     <= wt_r[1];
      out_weight_gpu     <= wt_r[2];
      out_cpu_bias       <= bias[6:0];
      out_gpu_demand_avg <= burst_r;
      out_ram_readahead  <= 4'd4 + 4'(ipr);
      out_reclaim_level  <= recl;
    end
  end

  assign out_valid = out_busy_r;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the windowed waste EMA tuner.
// ----------------------------------------------------------------------------
// Epoch samples go in over a valid/ready channel with random idling. A
// scoreboard keeps its own window ring, sums and weights, and predicts each
// result as the sample is accepted. Results come out under random stalls and
// are compared field by field, oldest first. The registers are rewritten
// between phases, only when the block is idle, with their extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wwet_pkg::*;

  localparam int      DEPTH      = 64;
  localparam int      SETTLE     = 500;
  localparam longint  LIMIT      = 3000000;
  localparam longint  ONE_W      = 65536;
  localparam longint  TWO_W      = 131072;
  localparam longint  FOUR_W     = 262144;
  localparam longint  QUARTER_W  = 16384;

  typedef struct {
    logic [31:0] dem [3];
    logic [31:0] gnt [3];
  } epoch_t;

  typedef struct {
    logic [18:0] w_cpu;
    logic [18:0] w_ram;
    logic [18:0] w_gpu;
    logic [6:0]  bias;
    logic [31:0] burst;
    logic [3:0]  prefetch;
    logic [7:0]  reclaim;
  } tuning_t;

  class tuner_scoreboard;
    longint unsigned ring_dem [DEPTH][3];
    longint unsigned ring_gnt [DEPTH][3];
    longint unsigned dem_sum [3];
    longint unsigned short_sum [3];
    longint unsigned wt [3];
    int              wr_ptr;
    int              filled;
    int              gain;
    int              min_fill;
    tuning_t         pending_q [$];
    int              errors;

    function new();
      for (int i = 0; i < DEPTH; i++)
        for (int r = 0; r < 3; r++) begin
          ring_dem[i][r] = 0;
          ring_gnt[i][r] = 0;
        end
      for (int r = 0; r < 3; r++) begin
        dem_sum[r] = 0;
        short_sum[r] = 0;
        wt[r] = ONE_W;
      end
      wr_ptr = 0;
      filled = 0;
      gain = 3;
      min_fill = 8;
      errors = 0;
    endfunction

    function longint unsigned shortfall(longint unsigned d, longint unsigned g);
      return (d > g) ? d - g : 0;
    endfunction

    function longint unsigned waste(longint unsigned d, longint unsigned s);
      longint unsigned dv;
      if (d == 0) return ONE_W;
      dv = d / 64;
      if (dv == 0) dv = 1;
      if (s >= 2 * dv) return TWO_W;
      return (s << 16) / dv;
    endfunction

    function longint unsigned step_weight(longint unsigned w, longint unsigned tgt);
      longint unsigned diff, delta, nw;
      diff = (tgt > w) ? tgt - w : w - tgt;
      delta = (diff * gain) / 64;
      if (tgt > w) nw = w + delta;
      else nw = (w > delta) ? w - delta : 1;
      if (nw > FOUR_W) nw = FOUR_W;
      if (nw < QUARTER_W) nw = QUARTER_W;
      return nw;
    endfunction

    function void note_input(epoch_t e);
      longint unsigned sig [3];
      longint unsigned tgt, ip_cpu, ip_ram, b, rc;
      tuning_t t;
      for (int r = 0; r < 3; r++) begin
        dem_sum[r] -= ring_dem[wr_ptr][r];
        short_sum[r] -= shortfall(ring_dem[wr_ptr][r], ring_gnt[wr_ptr][r]);
        ring_dem[wr_ptr][r] = e.dem[r];
        ring_gnt[wr_ptr][r] = e.gnt[r];
        dem_sum[r] += e.dem[r];
        short_sum[r] += shortfall(e.dem[r], e.gnt[r]);
      end
      wr_ptr = (wr_ptr + 1) % DEPTH;
      if (filled < DEPTH) filled++;
      if (filled < min_fill) return;
      for (int r = 0; r < 3; r++) sig[r] = waste(dem_sum[r], short_sum[r]);
      // cpu follows the signal reflected about 1.0
      tgt = (sig[0] > ONE_W) ? TWO_W - sig[0] : ONE_W;
      wt[0] = step_weight(wt[0], tgt);
      wt[1] = step_weight(wt[1], sig[1]);
      wt[2] = step_weight(wt[2], sig[2]);
      ip_cpu = wt[0] >> 16;
      ip_ram = wt[1] >> 16;
      b = 50 + ip_cpu * 10;
      if (b > 90) b = 90;
      rc = 64 + ip_ram * 16;
      if (rc > 255) rc = 255;
      t.w_cpu = wt[0][18:0];
      t.w_ram = wt[1][18:0];
      t.w_gpu = wt[2][18:0];
      t.bias = b[6:0];
      t.burst = 32'(dem_sum[2] / filled);
      t.prefetch = 4'(4 + ip_ram);
      t.reclaim = rc[7:0];
      pending_q.push_back(t);
    endfunction

    task report(string field, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
      errors++;
    endtask

    task check_result(tuning_t got);
      tuning_t want;
      if (pending_q.size() == 0) begin
        report("unexpected transfer", 1, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.w_cpu !== want.w_cpu) report("weight_cpu", got.w_cpu, want.w_cpu);
      if (got.w_ram !== want.w_ram) report("weight_ram", got.w_ram, want.w_ram);
      if (got.w_gpu !== want.w_gpu) report("weight_gpu", got.w_gpu, want.w_gpu);
      if (got.bias !== want.bias) report("cpu_bias", got.bias, want.bias);
      if (got.burst !== want.burst) report("gpu_demand_avg", got.burst, want.burst);
      if (got.prefetch !== want.prefetch)
        report("ram_readahead", got.prefetch, want.prefetch);
      if (got.reclaim !== want.reclaim) report("reclaim_level", got.reclaim, want.reclaim);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [6:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_cpu_demand, in_cpu_granted;
  logic [31:0] in_ram_demand, in_ram_granted;
  logic [31:0] in_gpu_demand, in_gpu_granted;
  logic        out_valid;
  logic        out_ready;
  logic [18:0] out_weight_cpu, out_weight_ram, out_weight_gpu;
  logic [6:0]  out_cpu_bias;
  logic [31:0] out_gpu_demand_avg;
  logic [3:0]  out_ram_readahead;
  logic [7:0]  out_reclaim_level;

  tuner_scoreboard sb = new();
  longint          cycles = 0;
  bit              quiet = 0;

  windowed_waste_ema_tuner u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cpu_demand(in_cpu_demand), .in_cpu_granted(in_cpu_granted),
    .in_ram_demand(in_ram_demand), .in_ram_granted(in_ram_granted),
    .in_gpu_demand(in_gpu_demand), .in_gpu_granted(in_gpu_granted),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_weight_cpu(out_weight_cpu), .out_weight_ram(out_weight_ram),
    .out_weight_gpu(out_weight_gpu), .out_cpu_bias(out_cpu_bias),
    .out_gpu_demand_avg(out_gpu_demand_avg), .out_ram_readahead(out_ram_readahead),
    .out_reclaim_level(out_reclaim_level)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // monitors sample pre-edge values, so ordering against the drivers is safe
  always @(posedge clk) begin
    epoch_t e;
    if (rst_n && in_valid && in_ready) begin
      e.dem[0] = in_cpu_demand; e.gnt[0] = in_cpu_granted;
      e.dem[1] = in_ram_demand; e.gnt[1] = in_ram_granted;
      e.dem[2] = in_gpu_demand; e.gnt[2] = in_gpu_granted;
      sb.note_input(e);
    end
  end

  always @(posedge clk) begin
    tuning_t t;
    if (rst_n && out_valid && out_ready) begin
      t.w_cpu = out_weight_cpu; t.w_ram = out_weight_ram; t.w_gpu = out_weight_gpu;
      t.bias = out_cpu_bias; t.burst = out_gpu_demand_avg;
      t.prefetch = out_ram_readahead; t.reclaim = out_reclaim_level;
      sb.check_result(t);
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= quiet || ($urandom_range(0, 99) >= 22);
  end

  // valid stays high after the transfer; the next idle cycle or wait drops it
  task send(epoch_t e);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cpu_demand <= e.dem[0]; in_cpu_granted <= e.gnt[0];
    in_ram_demand <= e.dem[1]; in_ram_granted <= e.gnt[1];
    in_gpu_demand <= e.dem[2]; in_gpu_granted <= e.gnt[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task wait_results();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task drain();
    wait_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(logic [0:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GAIN) sb.gain = val & 63;
    else sb.min_fill = val & 127;
    @(posedge clk);
  endtask

  function void rand_pair(output logic [31:0] d, output logic [31:0] g);
    case ($urandom_range(0, 6))
      0: begin d = 0; g = $urandom; end
      1: begin d = 32'hFFFF_FFFF; g = $urandom_range(0, 1) ? 0 : $urandom; end
      2: begin d = $urandom_range(0, 200); g = $urandom_range(0, 200); end
      3: begin d = $urandom; g = d - 32'($urandom % (64'(d) + 64'd1)); end
      4: begin d = $urandom; g = $urandom; end
      5: begin d = $urandom; g = d + 32'($urandom % (33'h1_0000_0000 - 33'(d))); end
      default: begin d = $urandom; g = d - (d >> $urandom_range(1, 8)); end
    endcase
  endfunction

  task send_random(int n);
    epoch_t e;
    for (int i = 0; i < n; i++) begin
      for (int r = 0; r < 3; r++) rand_pair(e.dem[r], e.gnt[r]);
      send(e);
    end
  endtask

  task send_uniform(logic [31:0] d, logic [31:0] g);
    epoch_t e;
    for (int r = 0; r < 3; r++) begin
      e.dem[r] = d;
      e.gnt[r] = g;
    end
    send(e);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    in_cpu_demand = '0; in_cpu_granted = '0;
    in_ram_demand = '0; in_ram_granted = '0;
    in_gpu_demand = '0; in_gpu_granted = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero demand, full shortfall, small demand, capped signal
    send_uniform(0, 0);
    send_uniform(32'hFFFF_FFFF, 0);
    send_uniform(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_uniform(0, 32'hFFFF_FFFF);
    send_uniform(63, 0);
    send_uniform(1, 0);
    send_uniform(100, 99);
    send_uniform(32'hFFFF_FFFF, 32'h8000_0000);
    send_uniform(32'hAAAA_AAAA, 32'h5555_5555);
    send_uniform(32'h5555_5555, 32'hAAAA_AAAA);
    send_uniform(32'hFFFF_FFFF, 0);
    send_uniform(32'hFFFF_FFFF, 0);
    send_uniform(0, 0);
    send_uniform(64, 64);
    send_uniform(32'h8000_0000, 32'h7FFF_FFFF);
    send_random(50);
    drain();

    // fastest gain, output on every sample; drive weights up toward 2.0 and down to the lower clamp
    write_reg(CFG_GAIN, 63);
    write_reg(CFG_MINS, 1);
    for (int i = 0; i < 10; i++) send_uniform(32'hFFFF_FFFF, 0);
    for (int i = 0; i < 10; i++) send_uniform(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(50);
    drain();

    // frozen weights with a full window required
    write_reg(CFG_GAIN, 0);
    write_reg(CFG_MINS, 64);
    send_random(70);
    drain();

    // threshold beyond the window: samples go in, nothing comes out
    write_reg(CFG_MINS, 100);
    send_random(20);
    drain();
    write_reg(CFG_MINS, 127);
    send_random(5);
    drain();

    write_reg(CFG_MINS, 0);
    write_reg(CFG_GAIN, $urandom_range(1, 62));
    send_random(50);
    drain();

    write_reg(CFG_GAIN, $urandom_range(0, 63));
    write_reg(CFG_MINS, $urandom_range(1, 64));
    quiet = 1;
    send_random(60);
    quiet = 0;
    // hold the sender until every result is back
    wait_results();
    send_random(60);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
